// ===== sv/sfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int CQ_DEPTH        = 2;
  localparam int OQ_DEPTH        = 4;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_HDR  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SECOND_HDR = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_LIMIT = 2'd2;

  localparam logic [7:0]  FIRST_HDR_RST  = 8'hFF;
  localparam logic [7:0]  SECOND_HDR_RST = 8'hFC;
  localparam logic [15:0] IDLE_LIMIT_RST = 16'd10;
  localparam logic [7:0]  MIN_LEN        = 8'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_SUM = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  payload_byte;
    logic [5:0]  byte_index;
    logic [6:0]  payload_length;
    logic        last;
    logic [31:0] error_total;
  } out_item_t;

  // one finished frame, handed from the parser to the emitter
  typedef struct packed {
    logic        is_err;
    logic [6:0]  plen;
    logic        bank;
    logic [31:0] err_total;
  } frame_cmd_t;

  // payload bank handed back by the emitter
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage
`default_nettype wire

// ===== sv/sfr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/sfr_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_fifo
// Small register queue with a power-of-two depth.
// ----------------------------------------------------------------------------
module sfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sfr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_front
// Frame parser: header hunt, length check, payload capture, running checksum.
// ----------------------------------------------------------------------------
module sfr_front
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_push,
  input  wire in_item_t              in_data,
  output logic                       in_full,
  output logic                       ram_we,
  output logic      [IDX_W:0]        ram_waddr,
  output logic      [7:0]            ram_wdata,
  output logic                       cq_push,
  output frame_cmd_t                 cq_data,
  input  wire logic                  cq_full,
  input  wire bank_rel_t             rel
);

  localparam logic [2:0] PH_HDR1 = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_SUM  = 3'd4;

  localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD + 2);

  logic [7:0]  first_hdr_r, second_hdr_r;
  logic [15:0] idle_limit_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  flen_r, flen_nxt;
  logic [6:0]  rcnt_r, rcnt_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [31:0] errs_r, errs_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        bank_r, bank_nxt;
  logic [1:0]  busy_r, busy_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] idle_inc;
  logic [6:0]  rcnt_inc;
  logic [6:0]  plen_cur;

  assign in_full  = cq_full || busy_r[bank_r];
  assign accept   = in_push && !in_full;
  assign b        = in_data.rx_byte;
  assign idle_inc = (idle_r != 16'hFFFF) ? 16'(idle_r + 1'b1) : idle_r;
  assign rcnt_inc = 7'(rcnt_r + 1'b1);
  assign plen_cur = 7'(flen_r - MIN_LEN);

  assign ram_waddr = {bank_r, rcnt_r[IDX_W-1:0]};
  assign ram_wdata = b;

  always_comb begin
    phase_nxt = phase_r;
    flen_nxt  = flen_r;
    rcnt_nxt  = rcnt_r;
    idle_nxt  = idle_r;
    errs_nxt  = errs_r;
    sum_nxt   = sum_r;
    bank_nxt  = bank_r;
    busy_nxt  = busy_r;
    ram_we    = 1'b0;
    cq_push   = 1'b0;
    cq_data   = '{is_err: STATUS_OK, plen: plen_cur, bank: bank_r, err_total: errs_r};

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (accept && in_data.operation == OP_IDLE) begin
      if (phase_r != PH_HDR1) begin
        if (idle_inc > idle_limit_r) begin
          // drop the partial frame
          phase_nxt = PH_HDR1;
          idle_nxt  = '0;
        end else begin
          idle_nxt = idle_inc;
        end
      end
    end else if (accept) begin
      idle_nxt = '0;
      unique case (phase_r)
        PH_HDR1: begin
          if (b == first_hdr_r) phase_nxt = PH_HDR2;
        end
        PH_HDR2: begin
          if (b == second_hdr_r) begin
            phase_nxt = PH_LEN;
          end else if (b != first_hdr_r) begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_LEN: begin
          if (b < MIN_LEN || {1'b0, b} > MAX_LEN) begin
            phase_nxt = PH_HDR1;
          end else begin
            flen_nxt  = b;
            rcnt_nxt  = '0;
            sum_nxt   = b;
            phase_nxt = (b == MIN_LEN) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          ram_we   = (rcnt_r < 7'(MAX_PAYLOAD));
          sum_nxt  = 8'(sum_r + b);
          rcnt_nxt = rcnt_inc;
          if (rcnt_inc >= plen_cur) phase_nxt = PH_SUM;
        end
        PH_SUM: begin
          cq_push = 1'b1;
          if (sum_r == b) begin
            if (plen_cur != '0) begin
              // hand the filled bank over, fill the other one next
              busy_nxt[bank_r] = 1'b1;
              bank_nxt         = !bank_r;
            end
          end else begin
            errs_nxt       = 32'(errs_r + 1'b1);
            cq_data.is_err = STATUS_BAD_SUM;
            cq_data.err_total = errs_nxt;
          end
          phase_nxt = PH_HDR1;
        end
        default: phase_nxt = PH_HDR1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_hdr_r  <= FIRST_HDR_RST;
      second_hdr_r <= SECOND_HDR_RST;
      idle_limit_r <= IDLE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FIRST_HDR:  first_hdr_r  <= cfg_wdata[7:0];
        REG_SECOND_HDR: second_hdr_r <= cfg_wdata[7:0];
        REG_IDLE_LIMIT: idle_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR1;
      flen_r  <= '0;
      rcnt_r  <= '0;
      idle_r  <= '0;
      errs_r  <= '0;
      sum_r   <= '0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      flen_r  <= flen_nxt;
      rcnt_r  <= rcnt_nxt;
      idle_r  <= idle_nxt;
      errs_r  <= errs_nxt;
      sum_r   <= sum_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sfr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_back
// Result emitter: turns each frame command into its run of results.
// ----------------------------------------------------------------------------
module sfr_back
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cq_empty,
  input  wire frame_cmd_t cq_data,
  output logic            cq_pop,
  output logic            ram_re,
  output logic [IDX_W:0]  ram_raddr,
  input  wire logic [7:0] ram_rdata,
  input  wire logic       of_full,
  output logic            of_push,
  output out_item_t       of_data,
  output bank_rel_t       rel
);

  localparam logic [1:0] BK_IDLE   = 2'd0;
  localparam logic [1:0] BK_SINGLE = 2'd1;
  localparam logic [1:0] BK_READ   = 2'd2;
  localparam logic [1:0] BK_PUSH   = 2'd3;

  logic [1:0] state_r, state_nxt;
  frame_cmd_t cmd_r, cmd_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic       idx_last;

  assign ram_raddr = {cmd_r.bank, idx_r[IDX_W-1:0]};
  assign idx_last  = (7'(idx_r) + 7'd1 == cmd_r.plen);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    cq_pop    = 1'b0;
    ram_re    = 1'b0;
    of_push   = 1'b0;
    rel       = '{valid: 1'b0, bank: cmd_r.bank};
    of_data   = '{status: cmd_r.is_err, payload_byte: '0, byte_index: '0,
                  payload_length: cmd_r.plen, last: 1'b1,
                  error_total: cmd_r.err_total};
    unique case (state_r)
      BK_IDLE: begin
        if (!cq_empty) begin
          cq_pop  = 1'b1;
          cmd_nxt = cq_data;
          idx_nxt = '0;
          state_nxt = (cq_data.is_err == STATUS_BAD_SUM || cq_data.plen == '0) ?
                      BK_SINGLE : BK_READ;
        end
      end
      BK_SINGLE: begin
        if (!of_full) begin
          of_push   = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      BK_READ: begin
        // issue the read only with room for its result
        if (!of_full) begin
          ram_re    = 1'b1;
          state_nxt = BK_PUSH;
        end
      end
      BK_PUSH: begin
        of_push              = 1'b1;
        of_data.payload_byte = ram_rdata;
        of_data.byte_index   = idx_r;
        of_data.last         = idx_last;
        if (idx_last) begin
          rel.valid = 1'b1;
          state_nxt = BK_IDLE;
        end else begin
          idx_nxt   = 6'(idx_r + 1'b1);
          state_nxt = BK_READ;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/serial_frame_receiver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Receive parser for header / length / checksum serial frames.
// ----------------------------------------------------------------------------
//  channel  ports                           payload
//  input    in_push, in_full, in_data       in_item_t (operation, rx_byte)
//  result   out_pop, out_empty, out_data    out_item_t
//  config   cfg_we, cfg_addr, cfg_wdata     first_header, second_header, idle_limit
//
//  The parser takes one input transaction per cycle while not stalled. The
//  emitter takes each frame off the frame queue, then for each result of a
//  good frame reads the payload RAM, then writes the result queue; an error
//  or empty-payload result is written to the result queue directly. Payload
//  goes to two RAM banks in turn; the input stalls while the bank to be
//  filled is still being emitted or the two-entry frame queue is full. Reset
//  is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module serial_frame_receiver
  import sfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_push,
  input  wire in_item_t              in_data,
  output logic                       in_full,
  input  wire logic                  out_pop,
  output out_item_t                  out_data,
  output logic                       out_empty
);

  localparam int IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

  logic       ram_we, ram_re;
  logic [IDX_W:0] ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;
  logic       cq_push, cq_full, cq_pop, cq_empty;
  frame_cmd_t cq_wdata, cq_rdata;
  logic       of_push, of_full;
  out_item_t  of_wdata;
  bank_rel_t  rel;

  sfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .IDX_W(IDX_W)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_push, .in_data, .in_full,
    .ram_we, .ram_waddr, .ram_wdata,
    .cq_push, .cq_data(cq_wdata), .cq_full, .rel
  );

  sfr_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_payload_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  sfr_fifo #(.WIDTH($bits(frame_cmd_t)), .DEPTH(CQ_DEPTH)) u_cmd_q (
    .clk, .rst_n, .push(cq_push), .wdata(cq_wdata), .full(cq_full),
    .pop(cq_pop), .rdata(cq_rdata), .empty(cq_empty)
  );

  sfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .IDX_W(IDX_W)) u_back (
    .clk, .rst_n, .cq_empty, .cq_data(cq_rdata), .cq_pop,
    .ram_re, .ram_raddr, .ram_rdata,
    .of_full, .of_push, .of_data(of_wdata), .rel
  );

  sfr_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OQ_DEPTH)) u_out_q (
    .clk, .rst_n, .push(of_push), .wdata(of_wdata), .full(of_full),
    .pop(out_pop), .rdata(out_data), .empty(out_empty)
  );

endmodule
`default_nettype wire

// ===== sv/sfr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the result channel of the serial frame receiver.
// ----------------------------------------------------------------------------
module sfr_checker
  import sfr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_pop,
  input wire logic      out_empty,
  input wire out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status == STATUS_BAD_SUM |->
      out_data.last && out_data.payload_byte == '0 && out_data.byte_index == '0)
    else $error("malformed checksum error result");

  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.payload_length == '0 |->
      out_data.last && out_data.byte_index == '0)
    else $error("malformed empty frame result");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status == STATUS_OK && out_data.payload_length != '0 |->
      7'(out_data.byte_index) < out_data.payload_length &&
      out_data.last == (7'(out_data.byte_index) + 7'd1 == out_data.payload_length))
    else $error("payload index out of run");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (
  .clk(clk), .rst_n(rst_n), .out_pop(out_pop), .out_empty(out_empty),
  .out_data(out_data)
);
`default_nettype wire

// ===== tb/sv/sfr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfr_scoreboard
// Watches the input, result and register ports of the serial frame receiver.
// Keeps its own frame parser, queues the results every accepted input
// transaction should produce and compares each popped result against them.
// ----------------------------------------------------------------------------
module sfr_scoreboard
  import sfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  input  logic                  in_full,
  input  in_item_t              in_data,
  input  logic                  out_pop,
  input  logic                  out_empty,
  input  out_item_t             out_data,
  output int                    fault_count,
  output int                    results_due
);

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    GET_LEN,
    GET_DATA,
    GET_SUM
  } parse_phase_t;

  logic [7:0]   first_hdr;
  logic [7:0]   second_hdr;
  logic [15:0]  idle_limit;

  parse_phase_t phase;
  logic [7:0]   frame_len;
  logic [6:0]   data_count;
  logic [15:0]  idle_run;
  logic [31:0]  sum_errors;
  logic [7:0]   payload_mem [MAX_PAYLOAD_DEF];

  out_item_t    frame_results_q [$];

  task automatic queue_result(input logic st, input logic [7:0] pb, input logic [5:0] idx,
                              input logic [6:0] plen, input logic lst);
    out_item_t r;
    r.status         = st;
    r.payload_byte   = pb;
    r.byte_index     = idx;
    r.payload_length = plen;
    r.last           = lst;
    r.error_total    = sum_errors;
    frame_results_q.push_back(r);
  endtask

  task automatic parse_event(input in_item_t it);
    logic [7:0] sum;
    int         plen;
    if (it.operation == OP_IDLE) begin
      if (phase != HUNT_FIRST) begin
        if (idle_run != 16'hFFFF) idle_run++;
        if (idle_run > idle_limit) begin
          phase    = HUNT_FIRST;
          idle_run = '0;
        end
      end
    end else begin
      idle_run = '0;
      case (phase)
        HUNT_FIRST: begin
          if (it.rx_byte == first_hdr) phase = HUNT_SECOND;
        end
        HUNT_SECOND: begin
          // the second header wins when both headers hold the same value
          if (it.rx_byte == second_hdr) phase = GET_LEN;
          else if (it.rx_byte != first_hdr) phase = HUNT_FIRST;
        end
        GET_LEN: begin
          if (it.rx_byte < MIN_LEN || it.rx_byte > MAX_PAYLOAD_DEF + 2) begin
            phase = HUNT_FIRST;
          end else begin
            frame_len  = it.rx_byte;
            data_count = '0;
            phase      = (it.rx_byte == MIN_LEN) ? GET_SUM : GET_DATA;
          end
        end
        GET_DATA: begin
          payload_mem[data_count] = it.rx_byte;
          data_count++;
          if (data_count >= frame_len - MIN_LEN) phase = GET_SUM;
        end
        GET_SUM: begin
          plen = frame_len - MIN_LEN;
          sum  = frame_len;
          for (int i = 0; i < plen; i++) sum += payload_mem[i];
          if (sum != it.rx_byte) begin
            sum_errors++;
            queue_result(STATUS_BAD_SUM, 8'h00, 6'd0, plen[6:0], 1'b1);
          end else if (plen == 0) begin
            queue_result(STATUS_OK, 8'h00, 6'd0, 7'd0, 1'b1);
          end else begin
            for (int i = 0; i < plen; i++)
              queue_result(STATUS_OK, payload_mem[i], i[5:0], plen[6:0], i == plen - 1);
          end
          phase = HUNT_FIRST;
        end
        default: phase = HUNT_FIRST;
      endcase
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (frame_results_q.size() == 0) begin
      $error("result transaction with nothing pending: %h", got);
      fault_count++;
    end else begin
      want = frame_results_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fault_count++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0d, got %0d", want.payload_byte, got.payload_byte);
        fault_count++;
      end
      if (got.byte_index !== want.byte_index) begin
        $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
        fault_count++;
      end
      if (got.payload_length !== want.payload_length) begin
        $error("payload_length: expected %0d, got %0d", want.payload_length,
               got.payload_length);
        fault_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fault_count++;
      end
      if (got.error_total !== want.error_total) begin
        $error("error_total: expected %0d, got %0d", want.error_total, got.error_total);
        fault_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      first_hdr  = FIRST_HDR_RST;
      second_hdr = SECOND_HDR_RST;
      idle_limit = IDLE_LIMIT_RST;
      phase      = HUNT_FIRST;
      frame_len  = '0;
      data_count = '0;
      idle_run   = '0;
      sum_errors = '0;
      frame_results_q.delete();
    end else begin
      if (out_pop && !out_empty) check_result(out_data);
      if (cfg_we) begin
        case (cfg_addr)
          REG_FIRST_HDR:  first_hdr  = cfg_wdata[7:0];
          REG_SECOND_HDR: second_hdr = cfg_wdata[7:0];
          REG_IDLE_LIMIT: idle_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (in_push && !in_full) parse_event(in_data);
    end
    results_due <= frame_results_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the serial frame receiver.
// Sends directed frames, then random well-formed, corrupted, truncated and
// noise traffic under several header and idle-limit settings, with random
// gaps on both queue sides. Checking is done by sfr_scoreboard.
// ----------------------------------------------------------------------------
module tb;
  import sfr_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = REG_FIRST_HDR;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_push   = 1'b0;
  in_item_t              in_data   = '0;
  logic                  in_full;
  logic                  out_pop   = 1'b0;
  out_item_t             out_data;
  logic                  out_empty;

  int                    fault_count;
  int                    results_due;
  int                    items_sent = 0;
  bit                    quiet      = 1'b0;
  logic [7:0]            cur_fh     = FIRST_HDR_RST;
  logic [7:0]            cur_sh     = SECOND_HDR_RST;
  logic [15:0]           cur_lim    = IDLE_LIMIT_RST;

  serial_frame_receiver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .out_empty (out_empty)
  );

  sfr_scoreboard u_scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_data    (out_data),
    .fault_count (fault_count),
    .results_due (results_due)
  );

  always #5 clk = ~clk;

  // result side: pop most cycles, stall now and then
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= quiet || ($urandom_range(99) >= 10);
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic push_item(input logic op, input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 10) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push         <= 1'b1;
    in_data.operation <= op;
    in_data.rx_byte   <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(OP_BYTE, b);
  endtask

  task automatic push_idle(input logic [7:0] b);
    push_item(OP_IDLE, b);
  endtask

  // occasional burst of idle polls inside a frame; may exceed a small limit
  task automatic maybe_idle();
    if ($urandom_range(9) == 0)
      repeat ($urandom_range((cur_lim < 5) ? cur_lim + 1 : 5, 1)) push_idle(8'($urandom));
  endtask

  task automatic send_frame(input logic [7:0] len, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    sum = len;
    if (cur_fh != cur_sh && $urandom_range(7) == 0) push_byte(cur_fh);
    push_byte(cur_fh);
    maybe_idle();
    push_byte(cur_sh);
    maybe_idle();
    push_byte(len);
    for (int i = 0; i < len - MIN_LEN; i++) begin
      maybe_idle();
      b = 8'($urandom);
      push_byte(b);
      sum += b;
    end
    maybe_idle();
    if (corrupt) sum ^= 8'($urandom_range(255, 1));
    push_byte(sum);
  endtask

  task automatic random_traffic(input int n_items);
    int         stop_at;
    int         pick;
    logic [7:0] len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = 8'(($urandom_range(7) == 0) ? MAX_PAYLOAD_DEF + 2 : $urandom_range(12, 2));
        send_frame(len, $urandom_range(99) < 15);
      end else if (pick < 80) begin
        push_byte(8'($urandom));
      end else if (pick < 85) begin
        push_idle(8'($urandom));
      end else if (pick < 92) begin
        push_byte(cur_fh);
        push_byte(cur_sh);
        push_byte(8'($urandom_range(1) ? $urandom_range(1) :
                      $urandom_range(255, MAX_PAYLOAD_DEF + 3)));
      end else if (cur_lim <= 20) begin
        // cut a frame short and let the idle limit drop it
        len = 8'($urandom_range(12, 3));
        push_byte(cur_fh);
        push_byte(cur_sh);
        push_byte(len);
        repeat ($urandom_range(len - 3, 0)) push_byte(8'($urandom));
        repeat (cur_lim + 1) push_idle(8'($urandom));
      end else begin
        push_byte(cur_fh);
        push_byte(8'($urandom));
      end
    end
  endtask

  // hold off until every queued result has been popped and the block is quiet
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] fh, input logic [7:0] sh,
                            input logic [15:0] lim);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_FIRST_HDR;
    cfg_wdata <= {8'h00, fh};
    @(posedge clk);
    cfg_addr  <= REG_SECOND_HDR;
    cfg_wdata <= {8'h00, sh};
    @(posedge clk);
    cfg_addr  <= REG_IDLE_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_fh  = fh;
    cur_sh  = sh;
    cur_lim = lim;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // idle poll while hunting is ignored
    push_idle(8'hA5);
    // empty payload
    push_byte(FIRST_HDR_RST); push_byte(SECOND_HDR_RST); push_byte(MIN_LEN); push_byte(8'h02);
    // repeated first header, one payload byte
    push_byte(FIRST_HDR_RST); push_byte(FIRST_HDR_RST); push_byte(SECOND_HDR_RST);
    push_byte(8'h03); push_byte(8'hAB); push_byte(8'hAE);
    // checksum mismatch on an empty frame
    push_byte(FIRST_HDR_RST); push_byte(SECOND_HDR_RST); push_byte(MIN_LEN); push_byte(8'h00);
    // length below and above range
    push_byte(FIRST_HDR_RST); push_byte(SECOND_HDR_RST); push_byte(8'h01);
    push_byte(FIRST_HDR_RST); push_byte(SECOND_HDR_RST); push_byte(8'(MAX_PAYLOAD_DEF + 3));
    // first header followed by a stray byte
    push_byte(FIRST_HDR_RST); push_byte(8'h00);

    random_traffic(70);

    settle();
    set_config(8'h00, 8'h00, 16'd0);
    random_traffic(70);

    settle();
    quiet = 1'b1;
    set_config(8'hFF, 8'hFF, 16'd65534);
    random_traffic(70);
    quiet = 1'b0;

    settle();
    set_config(8'($urandom), 8'($urandom), 16'($urandom_range(5, 1)));
    random_traffic(70);

    settle();
    set_config(8'hFF, 8'h00, 16'd3);
    random_traffic(70);

    settle();
    if (fault_count == 0 && results_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
